/* hdl/atfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfa_pkg
// shared types, constants and the radix-256 division step for the
// task-file address translator
// ----------------------------------------------------------------------------
package atfa_pkg;

    localparam int BLK_W     = 32;
    localparam int CNT_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = BLK_W / DIGIT_W;
    // input register plus two dividers of DIV_STEPS stages each
    localparam int NUM_PIPE  = 1 + 2 * DIV_STEPS;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LBA_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE    = 2'd3;

    localparam logic              LBA_MODE_RST = 1'b1;
    localparam logic [BYTE_W-1:0] HEADS_RST    = 8'd16;
    localparam logic [BYTE_W-1:0] SPT_RST      = 8'd63;
    localparam logic [BYTE_W-1:0] DRIVE_RST    = 8'hA0;
    localparam logic [BYTE_W-1:0] LBA_FLAG     = 8'h40;

    typedef struct packed {
        logic [BLK_W-1:0] block_number;
        logic [CNT_W-1:0] sector_count;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] count_byte;
        logic [BYTE_W-1:0] sector_byte;
        logic [BYTE_W-1:0] cylinder_low;
        logic [BYTE_W-1:0] cylinder_high;
        logic [BYTE_W-1:0] drive_head_byte;
    } rsp_t;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [BYTE_W-1:0] cnt;
        logic [BYTE_W-1:0] sec;   // remainder of the first division
        logic [BYTE_W-1:0] rem;   // running remainder
        logic [BLK_W-1:0]  q1;    // block / spt
        logic [BLK_W-1:0]  q2;    // q1 / heads
    } stage_t;

    // eight restoring steps: shifts one dividend digit into the remainder
    // returns {remainder, quotient digit}
    function automatic logic [2*BYTE_W-1:0] div_step8(
        input logic [BYTE_W-1:0]  rem_in,
        input logic [DIGIT_W-1:0] digit,
        input logic [BYTE_W-1:0]  divisor
    );
        logic [BYTE_W:0]    trial;
        logic [BYTE_W-1:0]  rem;
        logic [DIGIT_W-1:0] quo;
        rem = rem_in;
        quo = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            trial = {rem, digit[i]};
            if (trial >= {1'b0, divisor}) begin
                trial  = trial - {1'b0, divisor};
                quo[i] = 1'b1;
            end
            rem = trial[BYTE_W-1:0];
        end
        return {rem, quo};
    endfunction

endpackage

/* hdl/ata_task_file_address.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_task_file_address
// turns a block number and sector count into the five task-file bytes
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req) carries one command beat:
//   block number and sector count. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns the sector count, sector number, cylinder low/high and
//   drive/head bytes for that beat, in order, one result per command.
//   cfg_we / cfg_index / cfg_data write lba_mode, head_count,
//   sectors_per_track and drive_select; write them only while idle.
// pipeline and throughput
//   the input register loads on the edge that takes a beat; four radix-256
//   stages of block / spt, four of quotient / heads, and the output register
//   follow, and rsp_valid rises when the beat lands there. one beat per
//   cycle is taken while req_stall is low, each pipeline stage holding one
//   beat, so throughput is one command per clock while the output is not stalled.
// reset
//   rst_n clears all stage valid bits and loads lba mode, 16 heads,
//   63 sectors per track and drive select 0xa0.
// stall
//   a stalled result holds in the output register; upstream stages keep
//   filling any empty slots, and req_stall rises only once the pipe is full.
// ----------------------------------------------------------------------------
module ata_task_file_address
    import atfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    // configuration registers
    logic              lba_mode_reg;
    logic [BYTE_W-1:0] heads_reg;
    logic [BYTE_W-1:0] spt_reg;
    logic [BYTE_W-1:0] drive_reg;

    // zero geometry counts as one, so no divisor is ever zero
    logic [BYTE_W-1:0] heads_eff;
    logic [BYTE_W-1:0] spt_eff;

    // pipeline: stages 0..NUM_PIPE-1 hold work, stage NUM_PIPE is the output
    stage_t            pipe_reg  [NUM_PIPE];
    stage_t            pipe_next [NUM_PIPE];
    logic [NUM_PIPE:0] vld_reg;
    logic [NUM_PIPE:0] stage_adv;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lba_mode_reg <= LBA_MODE_RST;
            heads_reg    <= HEADS_RST;
            spt_reg      <= SPT_RST;
            drive_reg    <= DRIVE_RST;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_LBA_MODE: lba_mode_reg <= cfg_data[0];
                CFG_HEADS:    heads_reg    <= cfg_data;
                CFG_SPT:      spt_reg      <= cfg_data;
                CFG_DRIVE:    drive_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign heads_eff = (heads_reg == '0) ? BYTE_W'(1) : heads_reg;
    assign spt_eff   = (spt_reg == '0) ? BYTE_W'(1) : spt_reg;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        stage_adv[NUM_PIPE] = !vld_reg[NUM_PIPE] || !rsp_stall;
        for (int k = NUM_PIPE - 1; k >= 0; k--) begin
            stage_adv[k] = !vld_reg[k] || stage_adv[k+1];
        end
    end

    assign req_stall = !stage_adv[0];

    // input register, remainder starts from zero
    always_comb begin
        pipe_next[0]     = '0;
        pipe_next[0].blk = req.block_number;
        pipe_next[0].cnt = req.sector_count[BYTE_W-1:0];
    end

    genvar k;
    generate
        for (k = 1; k < NUM_PIPE; k++) begin : g_stage
            logic [2*BYTE_W-1:0] step;
            if (k <= DIV_STEPS) begin : g_div_spt
                // block / spt, one digit of the block number per stage
                always_comb begin
                    step = div_step8(pipe_reg[k-1].rem,
                        pipe_reg[k-1].blk[BLK_W-1-DIGIT_W*(k-1) -: DIGIT_W],
                        spt_eff);
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].rem = step[2*BYTE_W-1:BYTE_W];
                    pipe_next[k].q1  = {pipe_reg[k-1].q1[BLK_W-DIGIT_W-1:0],
                                        step[DIGIT_W-1:0]};
                end
            end
            else begin : g_div_heads
                // (block / spt) / heads, fresh remainder on the first stage
                logic [BYTE_W-1:0] rem_in;
                always_comb begin
                    rem_in = (k == DIV_STEPS + 1) ? '0 : pipe_reg[k-1].rem;
                    step = div_step8(rem_in,
                        pipe_reg[k-1].q1[BLK_W-1-DIGIT_W*(k-1-DIV_STEPS) -: DIGIT_W],
                        heads_eff);
                    pipe_next[k]     = pipe_reg[k-1];
                    if (k == DIV_STEPS + 1) begin
                        pipe_next[k].sec = pipe_reg[k-1].rem;
                    end
                    pipe_next[k].rem = step[2*BYTE_W-1:BYTE_W];
                    pipe_next[k].q2  = {pipe_reg[k-1].q2[BLK_W-DIGIT_W-1:0],
                                        step[DIGIT_W-1:0]};
                end
            end
        end
    endgenerate

    // task-file bytes from the last work stage
    always_comb begin
        rsp_next.count_byte = pipe_reg[NUM_PIPE-1].cnt;
        if (lba_mode_reg) begin
            rsp_next.sector_byte     = pipe_reg[NUM_PIPE-1].blk[7:0];
            rsp_next.cylinder_low    = pipe_reg[NUM_PIPE-1].blk[15:8];
            rsp_next.cylinder_high   = pipe_reg[NUM_PIPE-1].blk[23:16];
            rsp_next.drive_head_byte = {4'b0000, pipe_reg[NUM_PIPE-1].blk[27:24]}
                                       | LBA_FLAG | drive_reg;
        end
        else begin
            // remainder is below spt, so the plus one stays in a byte
            rsp_next.sector_byte     = pipe_reg[NUM_PIPE-1].sec + BYTE_W'(1);
            rsp_next.cylinder_low    = pipe_reg[NUM_PIPE-1].q2[7:0];
            rsp_next.cylinder_high   = pipe_reg[NUM_PIPE-1].q2[15:8];
            rsp_next.drive_head_byte = pipe_reg[NUM_PIPE-1].rem | drive_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (stage_adv[0]) begin
                vld_reg[0] <= req_valid;
            end
            for (int i = 1; i <= NUM_PIPE; i++) begin
                if (stage_adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // payload, loaded only when a beat moves in
    always_ff @(posedge clk) begin
        if (stage_adv[0] && req_valid) begin
            pipe_reg[0] <= pipe_next[0];
        end
        for (int i = 1; i < NUM_PIPE; i++) begin
            if (stage_adv[i] && vld_reg[i-1]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
        if (stage_adv[NUM_PIPE] && vld_reg[NUM_PIPE-1]) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = vld_reg[NUM_PIPE];
    assign rsp       = rsp_reg;

    // an accepted beat lands in the input register
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> vld_reg[0])
        else $error("accepted beat not captured");

    // an empty output register never pushes back upstream
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled with empty output");

    // input only stalls when every stage holds a beat and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&vld_reg) && rsp_stall)
        else $error("input stalled with a free stage");

    // a beat leaving the last work stage reaches the output
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NUM_PIPE-1] && stage_adv[NUM_PIPE] |=> rsp_valid)
        else $error("result lost at output register");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ata task-file address translator
// ----------------------------------------------------------------------------
// a table of directed commands runs first: extreme block numbers and counts,
// zero and full geometry, drive bits that overlap the head. rows whose bytes
// are plain to see carry them typed in, the rest go through a local
// translator. random phases under a range of register settings follow, with
// random gaps and stalls on both channels and one long output hold-off that
// backs the pipe up into req_stall. results are matched in order, field by
// field.
// ----------------------------------------------------------------------------
module tb_top;
    import atfa_pkg::*;

    localparam int PHASE_ITEMS = 140;
    localparam int NUM_PHASES  = 8;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_SLACK = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // shadow of the four configuration registers
    typedef struct packed {
        logic              lba_mode;
        logic [BYTE_W-1:0] head_count;
        logic [BYTE_W-1:0] sectors_per_track;
        logic [BYTE_W-1:0] drive_select;
    } geom_t;

    // one directed command: settings it runs under, the beat, and the
    // typed-in task-file bytes where they are obvious
    typedef struct {
        geom_t geom;
        req_t  beat;
        bit    typed;
        rsp_t  want;
    } vec_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LBA_MODE;
    logic [BYTE_W-1:0]    cfg_data = '0;

    geom_t    cur_geom;
    rsp_t     taskfile_q[$];
    vec_row_t vec_table[$];

    int  errors        = 0;
    int  beats_sent    = 0;
    int  results_seen  = 0;
    int  settings_used = 0;
    int  full_cycles   = 0;
    int  cycle_cnt     = 0;
    int  rx_wait       = 0;
    bit  no_idle       = 1'b0;
    logic hold_on      = 1'b0;

    ata_task_file_address u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // local translator: lba28 slicing or chs division
    // ------------------------------------------------------------------------
    function automatic rsp_t translate_address(input req_t beat, input geom_t g);
        rsp_t        r;
        logic [31:0] heads;
        logic [31:0] spt;
        logic [31:0] cyl;
        logic [31:0] hd;
        logic [31:0] sec;
        if (g.lba_mode)
        begin
            // top nibble of the block number is simply dropped
            cyl = {16'd0, beat.block_number[23:8]};
            hd  = {28'd0, beat.block_number[27:24]} | {24'd0, LBA_FLAG};
            sec = {24'd0, beat.block_number[7:0]};
        end
        else
        begin
            // a zero geometry register counts as one
            heads = (g.head_count == '0) ? 32'd1 : {24'd0, g.head_count};
            spt   = (g.sectors_per_track == '0) ? 32'd1 : {24'd0, g.sectors_per_track};
            cyl   = (beat.block_number / (heads * spt)) & 32'h0000_FFFF;
            hd    = (beat.block_number / spt) % heads;
            sec   = (beat.block_number % spt) + 32'd1;
        end
        r.count_byte      = beat.sector_count[7:0];
        r.sector_byte     = sec[7:0];
        r.cylinder_low    = cyl[7:0];
        r.cylinder_high   = cyl[15:8];
        // drive select is ored in whole, even over head or lba bits
        r.drive_head_byte = hd[7:0] | g.drive_select;
        return r;
    endfunction

    // block numbers: full range, small ones that keep the cylinder in
    // range, lba28 edges and track/cylinder boundaries
    function automatic logic [BLK_W-1:0] pick_block();
        logic [31:0] hs;
        logic [31:0] k;
        hs = ((cur_geom.head_count == '0) ? 32'd1 : {24'd0, cur_geom.head_count})
           * ((cur_geom.sectors_per_track == '0) ? 32'd1
              : {24'd0, cur_geom.sectors_per_track});
        k  = $urandom_range(0, 2000);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_FFFF);
            2: return $urandom_range(0, 32'h00FF_FFFF);
            3: return $urandom & 32'h0FFF_FFFF;
            4: return k * hs - 32'd1 + $urandom_range(0, 2);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h0FFF_FFFF;
                    default: return 32'h1000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        logic [CNT_W-1:0] c;
        // mostly legal counts, now and then 0 or 257..511
        if ($urandom_range(0, 7) == 0)
            c = CNT_W'($urandom_range(0, 511));
        else
            c = CNT_W'($urandom_range(1, 256));
        return c;
    endfunction

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic add_vec(input geom_t g, input logic [BLK_W-1:0] blk,
                           input logic [CNT_W-1:0] cnt, input bit typed,
                           input logic [39:0] want);
        vec_row_t row;
        row.geom              = g;
        row.beat.block_number = blk;
        row.beat.sector_count = cnt;
        row.typed             = typed;
        row.want              = want;
        vec_table.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // request side: gap, then hold the beat until it is taken
    // ------------------------------------------------------------------------
    task automatic send_beat(input req_t beat, input bit typed, input rsp_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (req_stall);
        taskfile_q.push_back(typed ? want : translate_address(beat, cur_geom));
        beats_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_pipe();
        req_valid <= 1'b0;
        while (taskfile_q.size() != 0)
            @(posedge clk);
    endtask

    // write all four registers on back-to-back cycles, only while idle
    task automatic apply_geometry(input geom_t g);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LBA_MODE;
        cfg_data  <= {{(BYTE_W-1){1'b0}}, g.lba_mode};
        @(posedge clk);
        cfg_index <= CFG_HEADS;
        cfg_data  <= g.head_count;
        @(posedge clk);
        cfg_index <= CFG_SPT;
        cfg_data  <= g.sectors_per_track;
        @(posedge clk);
        cfg_index <= CFG_DRIVE;
        cfg_data  <= g.drive_select;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_geom = g;
        settings_used++;
    endtask

    task automatic check_byte(input string field, input logic [7:0] exp_b,
                              input logic [7:0] act_b);
        if (act_b !== exp_b)
        begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s expected %h actual %h", $time, field, exp_b, act_b);
        end
    endtask

    // ------------------------------------------------------------------------
    // response side: check each taken beat, then draw the next stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (taskfile_q.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: unexpected result expected none actual %h",
                             $time, rsp);
            end
            else
            begin
                check_byte("count_byte", taskfile_q[0].count_byte, rsp.count_byte);
                check_byte("sector_byte", taskfile_q[0].sector_byte, rsp.sector_byte);
                check_byte("cylinder_low", taskfile_q[0].cylinder_low, rsp.cylinder_low);
                check_byte("cylinder_high", taskfile_q[0].cylinder_high,
                           rsp.cylinder_high);
                check_byte("drive_head_byte", taskfile_q[0].drive_head_byte,
                           rsp.drive_head_byte);
                void'(taskfile_q.pop_front());
            end
            rx_wait = pick_gap();
        end
        else if (rx_wait > 0)
            rx_wait--;
        rsp_stall <= hold_on || (rx_wait != 0);
        if (req_valid && req_stall)
            full_cycles++;
    end

    // long output hold-off while requests keep coming, to fill the pipe
    initial
    begin : hold_off_proc
        wait (results_seen >= 400);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, taskfile_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : main_proc
        geom_t g_rst;
        geom_t g_chs;
        geom_t g_zero;
        geom_t g_max;
        geom_t g_lba0;
        geom_t g_ovl;
        geom_t plan[NUM_PHASES];
        req_t  beat;

        g_rst  = {LBA_MODE_RST, HEADS_RST, SPT_RST, DRIVE_RST};
        g_chs  = {1'b0, 8'd16, 8'd63, 8'hA0};
        g_zero = {1'b0, 8'd0, 8'd0, 8'hFF};
        g_max  = {1'b0, 8'd255, 8'd255, 8'h00};
        g_lba0 = {1'b1, 8'd5, 8'd7, 8'h00};
        g_ovl  = {1'b0, 8'd16, 8'd63, 8'h0F};

        // after reset: lba, drive 0xa0
        add_vec(g_rst, 32'h0000_0000, 9'd1,   1, {8'h01, 8'h00, 8'h00, 8'h00, 8'hE0});
        add_vec(g_rst, 32'hFFFF_FFFF, 9'd256, 1, {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hEF});
        add_vec(g_rst, 32'h0FFF_FFFF, 9'd255, 1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hEF});
        // count of zero, block above 28 bits
        add_vec(g_rst, 32'h1000_0000, 9'd0,   1, {8'h00, 8'h00, 8'h00, 8'h00, 8'hE0});
        add_vec(g_rst, 32'h1234_5678, 9'd257, 1, {8'h01, 8'h78, 8'h56, 8'h34, 8'hE2});
        add_vec(g_rst, 32'hA5A5_A5A5, 9'd511, 1, {8'hFF, 8'hA5, 8'hA5, 8'hA5, 8'hE5});
        add_vec(g_rst, 32'h5A5A_5A5A, 9'd170, 1, {8'hAA, 8'h5A, 8'h5A, 8'h5A, 8'hEA});
        // chs, classic 16 heads x 63 sectors, track and cylinder edges
        add_vec(g_chs, 32'd0,         9'd1,   1, {8'h01, 8'h01, 8'h00, 8'h00, 8'hA0});
        add_vec(g_chs, 32'd62,        9'd8,   0, '0);
        add_vec(g_chs, 32'd63,        9'd16,  0, '0);
        add_vec(g_chs, 32'd1007,      9'd256, 0, '0);
        add_vec(g_chs, 32'd1008,      9'd2,   0, '0);
        // cylinder far beyond 16 bits
        add_vec(g_chs, 32'hFFFF_FFFF, 9'd256, 0, '0);
        // zero geometry behaves as one head, one sector
        add_vec(g_zero, 32'h0000_1234, 9'd1,   1, {8'h01, 8'h01, 8'h34, 8'h12, 8'hFF});
        add_vec(g_zero, 32'hFFFF_FFFF, 9'd256, 1, {8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF});
        add_vec(g_zero, 32'h0000_0000, 9'd300, 1, {8'h2C, 8'h01, 8'h00, 8'h00, 8'hFF});
        // full geometry
        add_vec(g_max, 32'd0,         9'd256, 1, {8'h00, 8'h01, 8'h00, 8'h00, 8'h00});
        add_vec(g_max, 32'd254,       9'd1,   1, {8'h01, 8'hFF, 8'h00, 8'h00, 8'h00});
        add_vec(g_max, 32'd65024,     9'd1,   0, '0);
        add_vec(g_max, 32'hFFFF_FFFF, 9'd1,   0, '0);
        // lba with drive select cleared
        add_vec(g_lba0, 32'h0F00_0000, 9'd1,   1, {8'h01, 8'h00, 8'h00, 8'h00, 8'h4F});
        add_vec(g_lba0, 32'hF0FF_FFFF, 9'd128, 1, {8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h40});
        // drive select bits on top of head 15
        add_vec(g_ovl, 32'd945,       9'd1,   1, {8'h01, 8'h01, 8'h00, 8'h00, 8'h0F});

        cur_geom = g_rst;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, registers rewritten whenever a row needs new ones
        foreach (vec_table[i])
        begin
            if (vec_table[i].geom != cur_geom)
            begin
                drain_pipe();
                apply_geometry(vec_table[i].geom);
            end
            send_beat(vec_table[i].beat, vec_table[i].typed, vec_table[i].want);
        end

        // random phases: reset values, classic chs, extremes, random geometry
        plan[0] = {1'b1, 8'd16, 8'd63, 8'($urandom)};
        plan[1] = g_chs;
        plan[2] = {1'b0, 8'd255, 8'd255, 8'($urandom)};
        plan[3] = {1'b0, 8'd1, 8'd1, 8'hB0};
        plan[4] = {1'b0, 8'd0, 8'd0, 8'($urandom)};
        plan[5] = {1'b0, 8'($urandom), 8'($urandom), 8'($urandom)};
        plan[6] = {1'b1, 8'($urandom), 8'($urandom), 8'hB0};
        plan[7] = {1'b0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom)};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipe();
            apply_geometry(plan[p]);
            // two phases run back to back with no idling on either side
            no_idle = (p == 1) || (p == 6);
            repeat (PHASE_ITEMS)
            begin
                beat.block_number = pick_block();
                beat.sector_count = pick_count();
                send_beat(beat, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (DRAIN_SLACK) @(posedge clk);

        $display("ran %0d beats under %0d register settings, %0d results checked",
                 beats_sent, settings_used, results_seen);
        $display("request side saw the pipe full for %0d cycles", full_cycles);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
